/* hw/rtl/tmva_pkg.sv */
package tmva_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // product, three-term sum, scaled b and full total widths
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int PSUM_W  = 2 * DATA_WIDTH + 2;
    localparam int BTERM_W = DATA_WIDTH + FRAC_BITS + 1;
    localparam int TOTAL_W = 2 * DATA_WIDTH + 3;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPOSE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BETA      = 8'd2;

    localparam logic [1:0] ALPHA_ZERO  = 2'd0;
    localparam logic [1:0] ALPHA_PLUS  = 2'd1;
    localparam logic [1:0] ALPHA_MINUS = 2'd2;

    localparam logic [1:0] BETA_CLEAR  = 2'd0;
    localparam logic [1:0] BETA_KEEP   = 2'd1;
    localparam logic [1:0] BETA_NEGATE = 2'd2;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        data_t      x_value;
        data_t      diag_entry;
        data_t      sub_entry;
        data_t      super_entry;
        data_t      b_value;
        logic       last_row;
    } in_item_t;

    typedef struct packed {
        data_t      result_value;
        logic       saturated;
        logic       last_result;
    } out_item_t;

    // one stored row of the window
    typedef struct packed {
        data_t      x_value;
        data_t      diag_entry;
        data_t      sub_entry;
        data_t      super_entry;
        data_t      b_value;
    } row_t;

    typedef struct packed {
        logic       prod_en;
        logic       prod_neg;
        logic       b_en;
        logic       b_neg;
    } scale_t;

    // one row result to compute: three coefficient/x pairs and the prior b
    typedef struct packed {
        data_t      lo_coef;
        data_t      lo_x;
        data_t      mid_coef;
        data_t      mid_x;
        data_t      hi_coef;
        data_t      hi_x;
        data_t      b_value;
        logic       last;
        scale_t     scale;
    } job_t;

endpackage

/* hw/rtl/tmva_cell.sv */
module tmva_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  tmva_pkg::row_t in_row,
    input  logic          in_valid,
    output tmva_pkg::row_t row,
    output logic          valid
);
    import tmva_pkg::*;

    row_t row_reg;
    logic valid_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= in_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    assign row   = row_reg;
    assign valid = valid_reg;

endmodule

/* hw/rtl/tmva_mac.sv */
module tmva_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              job_valid,
    input  tmva_pkg::job_t    job,
    output logic              out_valid,
    output tmva_pkg::out_item_t out_item
);
    import tmva_pkg::*;

    // stage 1: job register
    job_t                    s1_job_reg;
    logic                    s1_valid_reg;
    // stage 2: products
    logic signed [PROD_W-1:0] s2_p0_reg, s2_p1_reg, s2_p2_reg;
    data_t                   s2_b_reg;
    scale_t                  s2_scale_reg;
    logic                    s2_last_reg, s2_valid_reg;
    // stage 3: product sum and scaled b
    logic signed [PSUM_W-1:0]  s3_psum_reg;
    logic signed [BTERM_W-1:0] s3_bterm_reg;
    scale_t                  s3_scale_reg;
    logic                    s3_last_reg, s3_valid_reg;
    // output register
    out_item_t               out_reg;
    logic                    out_valid_reg;

    logic signed [PROD_W-1:0]  p0_next, p1_next, p2_next;
    logic signed [PSUM_W-1:0]  psum_next;
    logic signed [BTERM_W-1:0] bext, bshift, bterm_next;
    logic signed [TOTAL_W-1:0] pterm, total;
    logic [TOTAL_W-FRAC_BITS-DATA_WIDTH:0] upper;
    logic                      fits;
    out_item_t                 out_next;

    always_comb begin
        p0_next = PROD_W'(s1_job_reg.lo_coef) * PROD_W'(s1_job_reg.lo_x);
        p1_next = PROD_W'(s1_job_reg.mid_coef) * PROD_W'(s1_job_reg.mid_x);
        p2_next = PROD_W'(s1_job_reg.hi_coef) * PROD_W'(s1_job_reg.hi_x);
    end

    always_comb begin
        psum_next = PSUM_W'(s2_p0_reg) + PSUM_W'(s2_p1_reg) + PSUM_W'(s2_p2_reg);
        bext      = BTERM_W'(s2_b_reg);
        bshift    = bext <<< FRAC_BITS;
        if (!s2_scale_reg.b_en) begin
            bterm_next = '0;
        end else if (s2_scale_reg.b_neg) begin
            bterm_next = -bshift;
        end else begin
            bterm_next = bshift;
        end
    end

    always_comb begin
        if (!s3_scale_reg.prod_en) begin
            pterm = '0;
        end else if (s3_scale_reg.prod_neg) begin
            pterm = -TOTAL_W'(s3_psum_reg);
        end else begin
            pterm = TOTAL_W'(s3_psum_reg);
        end
        total = TOTAL_W'(s3_bterm_reg) + pterm;
        // floor shift keeps bits above the fraction; they must fit the data width
        upper = total[TOTAL_W-1:FRAC_BITS+DATA_WIDTH-1];
        fits  = (&upper) || !(|upper);
        out_next.last_result = s3_last_reg;
        out_next.saturated   = !fits;
        if (fits) begin
            out_next.result_value = total[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
        end else if (total[TOTAL_W-1]) begin
            out_next.result_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            out_next.result_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_job_reg   <= job;
            s2_p0_reg    <= p0_next;
            s2_p1_reg    <= p1_next;
            s2_p2_reg    <= p2_next;
            s2_b_reg     <= s1_job_reg.b_value;
            s2_scale_reg <= s1_job_reg.scale;
            s2_last_reg  <= s1_job_reg.last;
            s3_psum_reg  <= psum_next;
            s3_bterm_reg <= bterm_next;
            s3_scale_reg <= s2_scale_reg;
            s3_last_reg  <= s2_last_reg;
            out_reg      <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* hw/rtl/tridiagonal_matvec_accumulate_core.sv */
// Tridiagonal matrix-vector multiply-accumulate: b := alpha*op(A)*x + beta*b.
// Input channel s_valid/s_ready/s_data: one matrix row per item (x, diagonal,
// subdiagonal, superdiagonal, prior b, last_row flag). Result channel
// m_valid/m_ready/m_data: one updated b per item, in row order.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes transpose_mode (0),
// alpha_mode (1) and beta_mode (2); it is always ready. Write it only while idle.
// A row's result needs the next row's x, so it leaves when that row arrives; the
// last row of a column releases the held row's result and then its own.
// Throughput: one input item per cycle while the result channel is not stalled. A last
// row that follows a held row issues its two results one after the other into the
// single multiply-add pipeline; input is held off until the second has issued.
// A result passes the job register, the 32x32 multipliers, the product sum, then the
// final add and saturate into the output reg; the own result of a last row behind a
// held row issues after the held row's result, once the pipeline moves again.
// A window of two cells holds the current and previous row and shifts on accept.
// Reset (aresetn low, synchronous) empties the window and pipeline and loads the
// config defaults: no transpose, alpha +1, beta +1.
// When m_ready is low with a result waiting, the whole pipeline freezes and s_ready
// drops; nothing is lost and the pipeline resumes on the next taken result.
module tridiagonal_matvec_accumulate_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tmva_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tmva_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmva_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmva_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tmva_pkg::*;

    // config registers
    logic       transpose_reg;
    logic [1:0] alpha_reg, beta_reg;
    scale_t     scale;

    // second result of a last row, waiting for the pipeline to move
    logic       pend2_valid_reg, pend2_valid_next;
    job_t       pend2_job_reg;

    // window cells: cell 1 holds the pending row, cell 0 the row before it
    row_t       in_row, c0_row, c1_row;
    logic       c0_valid, c1_valid;

    logic       advance, accept;
    job_t       job_held, job_last, job_issue;
    logic       issue_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_reg <= 1'b0;
            alpha_reg     <= ALPHA_PLUS;
            beta_reg      <= BETA_KEEP;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TRANSPOSE: transpose_reg <= cfg_data[0];
                CFG_ALPHA:     alpha_reg     <= cfg_data[1:0];
                CFG_BETA:      beta_reg      <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    // unused alpha code acts as zero, unused beta code as keep
    always_comb begin
        scale.prod_en  = (alpha_reg == ALPHA_PLUS) || (alpha_reg == ALPHA_MINUS);
        scale.prod_neg = (alpha_reg == ALPHA_MINUS);
        scale.b_en     = (beta_reg != BETA_CLEAR);
        scale.b_neg    = (beta_reg == BETA_NEGATE);
    end

    // pipeline moves whenever the output register is free or being drained
    assign advance = !m_valid || m_ready;
    assign s_ready = advance && !pend2_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_row.x_value     = s_data.x_value;
        in_row.diag_entry  = s_data.diag_entry;
        in_row.sub_entry   = s_data.sub_entry;
        in_row.super_entry = s_data.super_entry;
        in_row.b_value     = s_data.b_value;
    end

    // cell 1 always takes the new row; its valid drops on a last row
    tmva_cell u_cell1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .in_row   (in_row),
        .in_valid (!s_data.last_row),
        .row      (c1_row),
        .valid    (c1_valid)
    );

    // cell 0 takes over the held row; cleared at column end
    tmva_cell u_cell0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .in_row   (c1_row),
        .in_valid (c1_valid && !s_data.last_row),
        .row      (c0_row),
        .valid    (c0_valid)
    );

    always_comb begin
        // result of the held row: lower term from cell 0, upper from the new x
        job_held.lo_coef  = c0_valid ? (transpose_reg ? c0_row.super_entry
                                                      : c0_row.sub_entry) : '0;
        job_held.lo_x     = c0_row.x_value;
        job_held.mid_coef = c1_row.diag_entry;
        job_held.mid_x    = c1_row.x_value;
        job_held.hi_coef  = transpose_reg ? c1_row.sub_entry : c1_row.super_entry;
        job_held.hi_x     = s_data.x_value;
        job_held.b_value  = c1_row.b_value;
        job_held.last     = 1'b0;
        job_held.scale    = scale;

        // result of the last row: lower term from the held row, no upper term
        job_last.lo_coef  = c1_valid ? (transpose_reg ? c1_row.super_entry
                                                      : c1_row.sub_entry) : '0;
        job_last.lo_x     = c1_row.x_value;
        job_last.mid_coef = s_data.diag_entry;
        job_last.mid_x    = s_data.x_value;
        job_last.hi_coef  = '0;
        job_last.hi_x     = '0;
        job_last.b_value  = s_data.b_value;
        job_last.last     = 1'b1;
        job_last.scale    = scale;
    end

    always_comb begin
        issue_valid = (accept && (c1_valid || s_data.last_row))
                   || (pend2_valid_reg && advance);
        if (pend2_valid_reg) begin
            job_issue = pend2_job_reg;
        end else if (c1_valid) begin
            job_issue = job_held;
        end else begin
            job_issue = job_last;
        end

        pend2_valid_next = pend2_valid_reg;
        if (accept && c1_valid && s_data.last_row) begin
            pend2_valid_next = 1'b1;
        end else if (pend2_valid_reg && advance) begin
            pend2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && c1_valid && s_data.last_row) begin
            pend2_job_reg <= job_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend2_valid_reg <= 1'b0;
        end else begin
            pend2_valid_reg <= pend2_valid_next;
        end
    end

    tmva_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .job_valid (issue_valid),
        .job       (job_issue),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

    // a prior row is only ever kept behind a held row
    a_prior_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        c0_valid |-> c1_valid)
        else $error("window cell 0 valid without a held row");

    // no new item while a second result waits to issue
    a_pend2_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        pend2_valid_reg |-> !s_ready)
        else $error("input accepted while a second result is pending");

    // a last row arriving behind a held row queues its own result
    a_last_queues_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && c1_valid && s_data.last_row) |=> pend2_valid_reg)
        else $error("second result of a last row not queued");

    // the queued result issues on the first cycle the pipeline moves
    a_pend2_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend2_valid_reg && advance) |=> !pend2_valid_reg)
        else $error("queued second result did not issue");

endmodule
